@@ rtl/core/drfl_pkg.sv @@
// Shared types, constants and codes of the dated rate floor lookup.
package drfl_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W    = 23;
    localparam int NUM_W    = 48;
    localparam int AMT_W    = 47;
    localparam int PROD_W   = 64;
    localparam int ENTRY_W  = KEY_W + NUM_W;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int STATUS_W = 3;
    localparam int ACC_W    = 96;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1000;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAYS_LEAP  = 5'd29;
    localparam logic [DAY_W-1:0]   DAYS_FEB   = 5'd28;
    localparam logic [DAY_W-1:0]   DAYS_SHORT = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_LONG  = 5'd31;
    localparam logic [46:0] AMOUNT_LIMIT_RESET = 47'd65536000;

    // reciprocal of 25 for years below 2^14
    localparam logic [12:0] RECIP25 = 13'd5243;
    localparam int          RECIP25_SHIFT = 17;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND  = 3'd0,
        ST_NONE   = 3'd1,
        ST_BADDAY = 3'd2,
        ST_NEG    = 3'd3,
        ST_BIG    = 3'd4,
        ST_STORED = 3'd5,
        ST_DUP    = 3'd6,
        ST_FULL   = 3'd7
    } status_t;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

@@ rtl/core/drfl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module drfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/dated_rate_floor_lookup_top.sv @@
// Top level of the dated rate floor lookup: sorted table, search, insert, multiply.
//
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tdata {number,day,month,year}, tuser command
// m_*      out  tvalid/tready      tdata product, tuser status
// cfg_*    in   cfg_wr_en          cfg_wr_data amount_limit
//
// A query runs a binary search on the table RAM read port, each step going
// through S_SRCH and S_SRCH_CMP, then forms the product from four passes of one
// 32x32 multiplier. A load runs the search, then moves each later entry up one.
// Reset empties the table at once. s_tready is low while an item is in work
// and while a finished beat cannot move into the output register.
module dated_rate_floor_lookup_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [71:0]                   s_tdata,   // year, month, day, number, pad
    input  logic [0:0]                    s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // product
    output logic [drfl_pkg::STATUS_W-1:0] m_tuser,   // status
    input  logic                          cfg_wr_en,
    input  logic [46:0]                   cfg_wr_data
);

    import drfl_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_CHECK    = 11'b00000000010,
        S_SRCH     = 11'b00000000100,
        S_SRCH_CMP = 11'b00000001000,
        S_PRED     = 11'b00000010000,
        S_PRED_CHK = 11'b00000100000,
        S_SHIFT    = 11'b00001000000,
        S_SHIFT_WR = 11'b00010000000,
        S_MUL      = 11'b00100000000,
        S_ROUND    = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [46:0] limit_reg;
    logic out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [PROD_W-1:0] out_product_reg, out_product_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [PROD_W-1:0] res_product_reg, res_product_next;
    logic cmd_reg, cmd_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0] day_reg, day_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] mag_reg, mag_next;
    logic neg_reg, neg_next;
    logic [2:0] step_reg, step_next;
    logic [63:0] prod_reg, prod_next;
    logic [6:0] shift_reg, shift_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] lo_dec;
    logic [26:0] y_scaled;
    logic [YEAR_W-1:0] y_div25;
    logic [YEAR_W-1:0] y_rem25;
    logic leap;
    logic [DAY_W-1:0] dim;
    logic date_ok;
    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0] rd_key;
    logic [NUM_W-1:0] rd_rate;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [78:0] q_mag;
    logic [79:0] q_ceil;
    logic out_free;

    assign key = {year_reg, month_reg, day_reg};
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_dec = lo_reg - CNT_W'(1);
    assign rd_key = ram_rdata[ENTRY_W-1:NUM_W];
    assign rd_rate = ram_rdata[NUM_W-1:0];
    assign out_free = !out_valid_reg || m_tready;

    assign y_scaled = 27'(year_reg) * 27'(RECIP25);
    assign y_div25 = y_scaled[RECIP25_SHIFT +: YEAR_W];
    assign y_rem25 = year_reg - YEAR_W'(y_div25 * YEAR_W'(25));
    assign leap = (year_reg[1:0] == 2'd0)
                  && ((y_rem25 != '0) || (year_reg[3:0] == 4'd0));

    always_comb
    begin
        case (month_reg)
            MONTH_FEB: dim = leap ? DAYS_LEAP : DAYS_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: dim = DAYS_SHORT;
            default: dim = DAYS_LONG;
        endcase
    end

    assign date_ok = (year_reg >= YEAR_MIN) && (year_reg <= YEAR_MAX)
                     && (month_reg != '0) && (month_reg <= MONTH_DEC)
                     && (day_reg != '0) && (day_reg <= dim);

    always_comb
    begin
        case (step_reg)
            3'd0: begin mul_a = mag_reg[31:0]; mul_b = num_reg[31:0]; end
            3'd1: begin mul_a = mag_reg[31:0]; mul_b = {17'b0, num_reg[46:32]}; end
            3'd2: begin mul_a = {16'b0, mag_reg[47:32]}; mul_b = num_reg[31:0]; end
            default: begin mul_a = {16'b0, mag_reg[47:32]}; mul_b = {17'b0, num_reg[46:32]}; end
        endcase
    end

    assign q_mag = acc_reg[94:16];
    assign q_ceil = {1'b0, q_mag} + 80'(acc_reg[15:0] != '0);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        out_valid_next = out_valid_reg;
        out_status_next = out_status_reg;
        out_product_next = out_product_reg;
        res_status_next = res_status_reg;
        res_product_next = res_product_reg;
        cmd_next = cmd_reg;
        year_next = year_reg;
        month_next = month_reg;
        day_next = day_reg;
        num_next = num_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        step_next = step_reg;
        prod_next = prod_reg;
        shift_next = shift_reg;
        acc_next = acc_reg;
        ram_we = 1'b0;
        ram_waddr = hi_reg[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = mid_calc[ADDR_W-1:0];
        s_tready = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd_next = s_tuser[0];
                    year_next = s_tdata[13:0];
                    month_next = s_tdata[17:14];
                    day_next = s_tdata[22:18];
                    num_next = s_tdata[70:23];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_product_next = '0;
                lo_next = '0;
                hi_next = count_reg;
                state_next = S_SRCH;
                if (!date_ok)
                begin
                    res_status_next = ST_BADDAY;
                    state_next = S_DONE;
                end
                else if (cmd_reg == CMD_QUERY && num_reg[NUM_W-1])
                begin
                    res_status_next = ST_NEG;
                    state_next = S_DONE;
                end
                else if (cmd_reg == CMD_QUERY && num_reg[AMT_W-1:0] > limit_reg)
                begin
                    res_status_next = ST_BIG;
                    state_next = S_DONE;
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next = mid_calc;
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    state_next = S_PRED;
                end
            end
            S_SRCH_CMP:
            begin
                if (rd_key <= key)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_PRED:
            begin
                ram_raddr = lo_dec[ADDR_W-1:0];
                hi_next = count_reg;
                if (lo_reg != '0)
                begin
                    state_next = S_PRED_CHK;
                end
                else if (cmd_reg == CMD_QUERY)
                begin
                    res_status_next = ST_NONE;
                    state_next = S_DONE;
                end
                else if (count_reg >= CNT_W'(TABLE_DEPTH))
                begin
                    res_status_next = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_PRED_CHK:
            begin
                neg_next = rd_rate[NUM_W-1];
                mag_next = rd_rate[NUM_W-1] ? NUM_W'(-rd_rate) : rd_rate;
                step_next = '0;
                acc_next = '0;
                if (cmd_reg == CMD_QUERY)
                begin
                    state_next = S_MUL;
                end
                else if (rd_key == key)
                begin
                    res_status_next = ST_DUP;
                    state_next = S_DONE;
                end
                else if (count_reg >= CNT_W'(TABLE_DEPTH))
                begin
                    res_status_next = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                ram_raddr = hi_reg[ADDR_W-1:0] - ADDR_W'(1);
                if (hi_reg == lo_reg)
                begin
                    ram_we = 1'b1;
                    ram_waddr = lo_reg[ADDR_W-1:0];
                    ram_wdata = {key, num_reg};
                    count_next = count_reg + CNT_W'(1);
                    res_status_next = ST_STORED;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                ram_we = 1'b1;
                hi_next = hi_reg - CNT_W'(1);
                state_next = S_SHIFT;
            end
            S_MUL:
            begin
                if (step_reg != 3'd0)
                begin
                    acc_next = acc_reg + (ACC_W'(prod_reg) << shift_reg);
                end
                prod_next = 64'(mul_a) * 64'(mul_b);
                case (step_reg)
                    3'd0: shift_next = 7'd0;
                    3'd1, 3'd2: shift_next = 7'd32;
                    default: shift_next = 7'd64;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                res_status_next = ST_FOUND;
                if (!neg_reg)
                begin
                    res_product_next = (q_mag > 79'h7FFFFFFFFFFFFFFF)
                        ? 64'h7FFFFFFFFFFFFFFF : q_mag[63:0];
                end
                else
                begin
                    res_product_next = (q_ceil > 80'h8000000000000000)
                        ? 64'h8000000000000000 : 64'(-q_ceil[63:0]);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_status_next = res_status_reg;
                    out_product_next = res_product_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            limit_reg <= AMOUNT_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        mid_reg <= mid_next;
        out_status_reg <= out_status_next;
        out_product_reg <= out_product_next;
        res_status_reg <= res_status_next;
        res_product_reg <= res_product_next;
        cmd_reg <= cmd_next;
        year_reg <= year_next;
        month_reg <= month_next;
        day_reg <= day_next;
        num_reg <= num_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        step_reg <= step_next;
        prod_reg <= prod_next;
        shift_reg <= shift_next;
        acc_reg <= acc_next;
    end

    drfl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_product_reg;
    assign m_tuser = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SHIFT || state_reg == S_SHIFT_WR))
        else $error("table write outside insert");

    a_mid_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH_CMP) |-> (mid_reg < count_reg))
        else $error("search probe beyond stored entries");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_SHIFT))
        else $error("entry count changed outside insert");

endmodule
